### rtl/explicit_diffusion_stencil_2d_assert.svh
// assertion macros shared by the diffusion stencil rtl
// used by files that check their own pipeline invariants; no other dependencies
`ifndef EXPLICIT_DIFFUSION_STENCIL_2D_ASSERT_SVH
`define EXPLICIT_DIFFUSION_STENCIL_2D_ASSERT_SVH

// condition implies consequence in the same cycle
`define EDS2D_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("eds2d same-cycle check failed");

// condition implies consequence in the next cycle
`define EDS2D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eds2d next-cycle check failed");

`endif

### rtl/eds2d_pkg.sv
// shared constants, types and helpers for the 2-d diffusion stencil
// no dependencies
`default_nettype none

package eds2d_pkg;

    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned GAIN_W      = 16;
    localparam int unsigned FRAC_W      = 16;
    localparam int unsigned LEN_REG_W   = 11;
    localparam int unsigned CNT_REG_W   = 13;
    localparam int unsigned LINE_W      = 12;
    localparam int unsigned MAX_LINES   = 4096;
    localparam int unsigned MIN_EXTENT  = 3;
    localparam int unsigned STENCIL_LAG = 2;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    // datapath widths: difference, gain product, product sum, rounded, result
    localparam int unsigned DIFF_W = VALUE_W + 2;
    localparam int unsigned PROD_W = DIFF_W + GAIN_W + 1;
    localparam int unsigned SUM_W  = PROD_W + 1;
    localparam int unsigned RND_W  = SUM_W - FRAC_W;
    localparam int unsigned RES_W  = RND_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_X      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 2'd3;

    typedef struct packed {
        logic emit;   // item completes an interior cell
        logic eot;    // that cell is the last interior cell of the tile
        logic fresh;  // line buffer entry never written, reads as zero
    } t_pos_flags;

    function automatic logic [CNT_REG_W-1:0] clamp_count(input logic [CNT_REG_W-1:0] v);
        logic [CNT_REG_W-1:0] r;
        if (v < CNT_REG_W'(MIN_EXTENT)) begin
            r = CNT_REG_W'(MIN_EXTENT);
        end else if (v > CNT_REG_W'(MAX_LINES)) begin
            r = CNT_REG_W'(MAX_LINES);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/explicit_diffusion_stencil_2d.sv
// an accepted interior beat passes stages s1, s2, s3 and the output register in that order
// throughput: one cell per cycle, set by one read and one write per cycle on each line ram
// a sink stall drops input ready in the same cycle once all four stages hold interior beats
// reset (synchronous, active low): gains 0, line length 3, line count 3, positions 0;
// the line rams are not swept: a fill count makes never-written entries read as zero
`default_nettype none

module explicit_diffusion_stencil_2d import eds2d_pkg::*; #(
    parameter int unsigned MAX_LINE = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [VALUE_W-1:0]    i_s_axis_tdata,   // [31:0] sample
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [VALUE_W-1:0]         o_m_axis_tdata,   // [31:0] new_value
    output logic                       o_m_axis_tlast    // end_of_tile
);

    localparam int unsigned AW = $clog2(MAX_LINE);
    localparam int unsigned LW = $clog2(MAX_LINE + 1);

    logic [GAIN_W-1:0]    r_gain_x, r_gain_y;
    logic [LW-1:0]        r_len;
    logic [CNT_REG_W-1:0] r_cnt;

    logic [LEN_REG_W-1:0] len_raw;
    logic [LW-1:0]        n_len;

    logic                 accept;
    logic [AW-1:0]        rd_addr;
    t_pos_flags           flags;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [VALUE_W-1:0]   newer_wdata, older_wdata, newer_q, older_q;

    // registers keep the clamped line length and line count
    always_comb begin
        len_raw = i_cfg_wdata[LEN_REG_W-1:0];
        if (len_raw < LEN_REG_W'(MIN_EXTENT)) begin
            n_len = LW'(MIN_EXTENT);
        end else if (32'(len_raw) > MAX_LINE) begin
            n_len = LW'(MAX_LINE);
        end else begin
            n_len = LW'(len_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_x <= '0;
            r_gain_y <= '0;
            r_len    <= LW'(MIN_EXTENT);
            r_cnt    <= CNT_REG_W'(MIN_EXTENT);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_GAIN_X:      r_gain_x <= i_cfg_wdata;
                REG_GAIN_Y:      r_gain_y <= i_cfg_wdata;
                REG_LINE_LENGTH: r_len    <= n_len;
                REG_LINE_COUNT:  r_cnt    <= clamp_count(i_cfg_wdata[CNT_REG_W-1:0]);
                default: ;
            endcase
        end
    end

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    eds2d_pos_ctrl #(
        .MAX_LINE (MAX_LINE)
    ) u_pos_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_len     (r_len),
        .i_cnt     (r_cnt),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .o_addr    (rd_addr),
        .o_flags   (flags)
    );

    // line one back
    eds2d_line_ram #(
        .DEPTH (MAX_LINE),
        .WIDTH (VALUE_W)
    ) u_newer_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (newer_wdata),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (newer_q)
    );

    // line two back
    eds2d_line_ram #(
        .DEPTH (MAX_LINE),
        .WIDTH (VALUE_W)
    ) u_older_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (older_wdata),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (older_q)
    );

    eds2d_stencil #(
        .MAX_LINE (MAX_LINE)
    ) u_stencil (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_x           ($signed(i_s_axis_tdata)),
        .i_addr        (rd_addr),
        .i_flags       (flags),
        .o_in_ready    (o_s_axis_tready),
        .i_newer_q     (newer_q),
        .i_older_q     (older_q),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_newer_wdata (newer_wdata),
        .o_older_wdata (older_wdata),
        .i_gain_x      (r_gain_x),
        .i_gain_y      (r_gain_y),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_value       (o_m_axis_tdata),
        .o_last        (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

### rtl/eds2d_line_ram.sv
// one line buffer: simple dual-port synchronous ram, registered read
// no dependencies
`default_nettype none

module eds2d_line_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned WIDTH = 32,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/eds2d_pos_ctrl.sv
// raster position counters, stencil flags and line buffer fill count
// depends on eds2d_pkg
`default_nettype none

module eds2d_pos_ctrl import eds2d_pkg::*; #(
    parameter int unsigned MAX_LINE = 1024,
    localparam int unsigned AW      = $clog2(MAX_LINE),
    localparam int unsigned LW      = $clog2(MAX_LINE + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [LW-1:0]        i_len,
    input  wire logic [CNT_REG_W-1:0] i_cnt,
    input  wire logic                 i_wr_en,
    input  wire logic [AW-1:0]        i_wr_addr,
    output logic      [AW-1:0]        o_addr,
    output t_pos_flags                o_flags
);

    logic [AW-1:0]        r_cell;
    logic [LINE_W-1:0]    r_line;
    logic [LW-1:0]        r_fill;

    logic                 wrap_cell;
    logic [CNT_REG_W-1:0] line_pre;
    logic [AW-1:0]        p;
    logic [LINE_W-1:0]    l;
    logic [LW-1:0]        p_inc;
    logic [CNT_REG_W-1:0] l_inc;

    // wrap left over from a shorter line or tile set while idle
    always_comb begin
        wrap_cell = LW'(r_cell) >= i_len;
        line_pre  = wrap_cell ? CNT_REG_W'(r_line) + CNT_REG_W'(1) : CNT_REG_W'(r_line);
        p         = wrap_cell ? '0 : r_cell;
        l         = (line_pre >= i_cnt) ? '0 : line_pre[LINE_W-1:0];
        p_inc     = LW'(p) + LW'(1);
        l_inc     = CNT_REG_W'(l) + CNT_REG_W'(1);
    end

    assign o_addr        = p;
    assign o_flags.emit  = (l >= LINE_W'(STENCIL_LAG)) && (p >= AW'(STENCIL_LAG));
    assign o_flags.eot   = (CNT_REG_W'(l) == i_cnt - CNT_REG_W'(1))
                           && (LW'(p) == i_len - LW'(1));
    assign o_flags.fresh = LW'(p) >= r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= '0;
            r_line <= '0;
        end else if (i_accept) begin
            if (p_inc >= i_len) begin
                r_cell <= '0;
                r_line <= (l_inc >= i_cnt) ? '0 : l_inc[LINE_W-1:0];
            end else begin
                r_cell <= p_inc[AW-1:0];
                r_line <= l;
            end
        end
    end

    // positions are always written in ascending order from zero,
    // so the written entries are exactly those below the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_wr_en && (LW'(i_wr_addr) >= r_fill)) begin
            r_fill <= LW'(i_wr_addr) + LW'(1);
        end
    end

endmodule

`default_nettype wire

### rtl/eds2d_stencil.sv
// stencil window, line buffer write-back and fixed-point update pipeline
// depends on eds2d_pkg and explicit_diffusion_stencil_2d_assert.svh
`default_nettype none
`include "explicit_diffusion_stencil_2d_assert.svh"

module eds2d_stencil import eds2d_pkg::*; #(
    parameter int unsigned MAX_LINE = 1024,
    localparam int unsigned AW      = $clog2(MAX_LINE)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire logic signed [VALUE_W-1:0] i_x,
    input  wire logic [AW-1:0]             i_addr,
    input  wire t_pos_flags                i_flags,
    output logic                           o_in_ready,
    input  wire logic [VALUE_W-1:0]        i_newer_q,
    input  wire logic [VALUE_W-1:0]        i_older_q,
    output logic                           o_ram_we,
    output logic [AW-1:0]                  o_ram_waddr,
    output logic [VALUE_W-1:0]             o_newer_wdata,
    output logic [VALUE_W-1:0]             o_older_wdata,
    input  wire logic [GAIN_W-1:0]         i_gain_x,
    input  wire logic [GAIN_W-1:0]         i_gain_y,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [VALUE_W-1:0]             o_value,
    output logic                           o_last
);

    // window: centre, north, west, east
    logic signed [VALUE_W-1:0] r_w_centre, r_w_north, r_w_west, r_w_east;

    logic                      r_s1_v;
    logic signed [VALUE_W-1:0] r_s1_x;
    logic [AW-1:0]             r_s1_addr;
    t_pos_flags                r_s1_flags;

    logic                      r_s2_v;
    logic signed [DIFF_W-1:0]  r_s2_dxx, r_s2_dyy;
    logic signed [VALUE_W-1:0] r_s2_c;
    logic                      r_s2_eot;

    logic                      r_s3_v;
    logic signed [PROD_W-1:0]  r_s3_px, r_s3_py;
    logic signed [VALUE_W-1:0] r_s3_c;
    logic                      r_s3_eot;

    logic                      r_out_v;
    logic [VALUE_W-1:0]        r_out_value;
    logic                      r_out_last;

    logic                      free3, free2, free1, s1_move;
    logic signed [VALUE_W-1:0] south, older_here;
    logic signed [DIFF_W-1:0]  n_dxx, n_dyy;
    logic signed [PROD_W-1:0]  n_px, n_py;
    logic signed [SUM_W-1:0]   sum_rnd;
    logic signed [RND_W-1:0]   rnd;
    logic signed [RES_W-1:0]   res;
    logic [VALUE_W-1:0]        n_value;

    // each stage takes a beat when the next one is empty or moving on
    assign free3      = !r_out_v || i_ready;
    assign free2      = !r_s3_v || free3;
    assign free1      = !r_s2_v || free2;
    assign s1_move    = r_s1_v && (!r_s1_flags.emit || free1);
    assign o_in_ready = !r_s1_v || s1_move;

    always_comb begin
        south      = r_s1_flags.fresh ? '0 : $signed(i_newer_q);
        older_here = r_s1_flags.fresh ? '0 : $signed(i_older_q);
        n_dxx = DIFF_W'(r_w_east) + DIFF_W'(r_w_west) - (DIFF_W'(r_w_centre) <<< 1);
        n_dyy = DIFF_W'(south) + DIFF_W'(r_w_north) - (DIFF_W'(r_w_centre) <<< 1);
    end

    assign o_ram_we      = s1_move;
    assign o_ram_waddr   = r_s1_addr;
    assign o_newer_wdata = r_s1_x;
    assign o_older_wdata = south;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_v <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_x     <= i_x;
            r_s1_addr  <= i_addr;
            r_s1_flags <= i_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_centre <= '0;
            r_w_north  <= '0;
            r_w_west   <= '0;
            r_w_east   <= '0;
        end else if (s1_move) begin
            r_w_north  <= r_w_centre;
            r_w_centre <= south;
            r_w_west   <= older_here;
            r_w_east   <= r_s1_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (free1) begin
            r_s2_v <= s1_move && r_s1_flags.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (free1 && s1_move && r_s1_flags.emit) begin
            r_s2_dxx <= n_dxx;
            r_s2_dyy <= n_dyy;
            r_s2_c   <= r_w_centre;
            r_s2_eot <= r_s1_flags.eot;
        end
    end

    // gains are unsigned q0.16, zero-extended before the signed multiply
    always_comb begin
        n_px = r_s2_dxx * $signed({1'b0, i_gain_x});
        n_py = r_s2_dyy * $signed({1'b0, i_gain_y});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (free2) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (free2 && r_s2_v) begin
            r_s3_px  <= n_px;
            r_s3_py  <= n_py;
            r_s3_c   <= r_s2_c;
            r_s3_eot <= r_s2_eot;
        end
    end

    // round half up to q16.16 by arithmetic shift, add centre, saturate
    always_comb begin
        sum_rnd = SUM_W'(r_s3_px) + SUM_W'(r_s3_py) + SUM_W'(1 << (FRAC_W - 1));
        rnd     = sum_rnd[SUM_W-1:FRAC_W];
        res     = RES_W'(r_s3_c) + RES_W'(rnd);
        if (res[RES_W-1] && !(&res[RES_W-2:VALUE_W-1])) begin
            n_value = {1'b1, {(VALUE_W-1){1'b0}}};
        end else if (!res[RES_W-1] && (|res[RES_W-2:VALUE_W-1])) begin
            n_value = {1'b0, {(VALUE_W-1){1'b1}}};
        end else begin
            n_value = res[VALUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (free3) begin
            r_out_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (free3 && r_s3_v) begin
            r_out_value <= n_value;
            r_out_last  <= r_s3_eot;
        end
    end

    assign o_valid = r_out_v;
    assign o_value = r_out_value;
    assign o_last  = r_out_last;

    `EDS2D_ASSERT_NOW(a_eot_is_interior, i_clk, i_rst_n, r_s1_v && r_s1_flags.eot, r_s1_flags.emit)
    `EDS2D_ASSERT_NOW(a_no_rw_collision, i_clk, i_rst_n, i_accept && s1_move, i_addr != r_s1_addr)
    `EDS2D_ASSERT_NEXT(a_out_needs_s3, i_clk, i_rst_n, !r_s3_v && !r_out_v, !r_out_v)

endmodule

`default_nettype wire

### tb/sv/explicit_diffusion_stencil_2d_test.sv
// self-checking testbench for the 2-d explicit diffusion stencil: streams tiles with random
// gaps and stalls, predicts every interior cell and compares it with the output beats
// depends on eds2d_pkg and explicit_diffusion_stencil_2d
module explicit_diffusion_stencil_2d_test;
    import eds2d_pkg::*;

    localparam int LINE_CAP       = 1024;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_ITEMS   = 600;

    localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;
    localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               tile_end;
    } t_cell_result;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic [VALUE_W-1:0]    s_data;
    logic                  m_ready;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [VALUE_W-1:0]    o_m_axis_tdata;
    logic                  o_m_axis_tlast;

    explicit_diffusion_stencil_2d #(
        .MAX_LINE(LINE_CAP)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_data),        // [31:0] sample
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (o_m_axis_tdata), // [31:0] new_value
        .o_m_axis_tlast (o_m_axis_tlast)  // end_of_tile
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of the registers and of the stencil state
    logic [GAIN_W-1:0]    gain_x_reg      = '0;
    logic [GAIN_W-1:0]    gain_y_reg      = '0;
    logic [LEN_REG_W-1:0] line_length_reg = LEN_REG_W'(MIN_EXTENT);
    logic [CNT_REG_W-1:0] line_count_reg  = CNT_REG_W'(MIN_EXTENT);
    longint               older_line [LINE_CAP];
    longint               newer_line [LINE_CAP];
    longint               win_centre, win_north, win_west, win_east;
    int                   cell_pos, line_pos;

    t_cell_result expected_cells[$];
    int           mismatch_count = 0;
    int           idle_cycles    = 0;
    bit           sender_gaps    = 1'b0;
    bit           sink_stalls    = 1'b0;

    function automatic int cells_per_line();
        if (line_length_reg < LEN_REG_W'(MIN_EXTENT)) return MIN_EXTENT;
        if (line_length_reg > LEN_REG_W'(LINE_CAP)) return LINE_CAP;
        return int'(line_length_reg);
    endfunction

    function automatic int lines_per_tile();
        if (line_count_reg < CNT_REG_W'(MIN_EXTENT)) return MIN_EXTENT;
        if (line_count_reg > CNT_REG_W'(MAX_LINES)) return MAX_LINES;
        return int'(line_count_reg);
    endfunction

    // one accepted cell: update the window and line stores, queue the finished interior cell
    task automatic advance_stencil(input logic [VALUE_W-1:0] raw);
        int           len, cnt;
        longint       x, south, older_here, dxx, dyy, prod_sum, updated;
        t_cell_result res;
        len = cells_per_line();
        cnt = lines_per_tile();
        if (cell_pos >= len) begin
            cell_pos = 0;
            line_pos++;
        end
        if (line_pos >= cnt) line_pos = 0;
        x          = longint'($signed(raw));
        south      = newer_line[cell_pos];
        older_here = older_line[cell_pos];
        if (line_pos >= 2 && cell_pos >= 2) begin
            dxx      = win_east + win_west - 2 * win_centre;
            dyy      = south + win_north - 2 * win_centre;
            prod_sum = dxx * longint'(gain_x_reg) + dyy * longint'(gain_y_reg);
            // round half up: floor((s + half) / 2^16)
            updated  = win_centre + ((prod_sum + 32768) >>> FRAC_W);
            if (updated > 64'sd2147483647) updated = 64'sd2147483647;
            if (updated < -64'sd2147483648) updated = -64'sd2147483648;
            res.value    = updated[VALUE_W-1:0];
            res.tile_end = (line_pos == cnt - 1) && (cell_pos == len - 1);
            expected_cells.push_back(res);
        end
        win_north  = win_centre;
        win_centre = south;
        win_west   = older_here;
        win_east   = x;
        older_line[cell_pos] = south;
        newer_line[cell_pos] = x;
        cell_pos++;
        if (cell_pos >= len) begin
            cell_pos = 0;
            line_pos++;
            if (line_pos >= cnt) line_pos = 0;
        end
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap_len();
        if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic send_sample(input logic [VALUE_W-1:0] v);
        int gap;
        gap = 0;
        if (sender_gaps && $urandom_range(0, 99) < 35) gap = pick_gap_len();
        @(negedge clk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= v;
        do @(posedge clk); while (!o_s_axis_tready);
        advance_stencil(v);
    endtask

    // stop sending, let every expected beat arrive, then let ghost cells leave the pipeline
    task automatic drain_results();
        @(negedge clk);
        s_valid <= 1'b0;
        while (expected_cells.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_GAIN_X:      gain_x_reg      = val;
            REG_GAIN_Y:      gain_y_reg      = val;
            REG_LINE_LENGTH: line_length_reg = val[LEN_REG_W-1:0];
            REG_LINE_COUNT:  line_count_reg  = val[CNT_REG_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [VALUE_W-1:0] pick_sample(input bit rough,
                                                       input logic [VALUE_W-1:0] level);
        int r;
        r = $urandom_range(0, 99);
        if (r < (rough ? 50 : 8)) return $urandom;
        if (r < (rough ? 70 : 12)) begin
            case ($urandom_range(0, 4))
                0: return VAL_MAX;
                1: return VAL_MIN;
                2: return '0;
                3: return '1;
                default: return 32'd1;
            endcase
        end
        // smooth field around a level, so results rarely saturate
        return level + VALUE_W'($urandom_range(0, 1 << 20)) - VALUE_W'(1 << 19);
    endfunction

    // gains 0, 3x3 tile: one result equal to the centre, marked as tile end
    task automatic test_reset_defaults();
        logic [VALUE_W-1:0] tile [9];
        tile = '{VAL_MIN, VAL_MAX, '0, '1, 32'h1234_5678, 32'd1, VAL_MIN, VAL_MAX, 32'hffff_0000};
        foreach (tile[i]) send_sample(tile[i]);
        drain_results();
    endtask

    // full gains, centre at one extreme with every neighbour at the other
    task automatic test_saturation();
        logic [VALUE_W-1:0] tile [12];
        write_reg(REG_GAIN_X, '1);
        write_reg(REG_GAIN_Y, '1);
        write_reg(REG_LINE_LENGTH, CFG_DATA_W'(4));
        write_reg(REG_LINE_COUNT, CFG_DATA_W'(3));
        tile = '{'0, VAL_MIN, VAL_MAX, '0,
                 VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX,
                 '0, VAL_MIN, VAL_MAX, '0};
        foreach (tile[i]) send_sample(tile[i]);
        drain_results();
    endtask

    // extents below the minimum clamp to 3; a difference just below minus one half rounds down
    task automatic test_small_extents();
        logic [VALUE_W-1:0] tile [9];
        write_reg(REG_GAIN_X, CFG_DATA_W'(1));
        write_reg(REG_GAIN_Y, '0);
        write_reg(REG_LINE_LENGTH, '0);
        write_reg(REG_LINE_COUNT, CFG_DATA_W'(1));
        tile = '{'0, 32'hffff_7fff, '0, '0, '0, '0, '0, '0, '0};
        foreach (tile[i]) send_sample(tile[i]);
        drain_results();
        write_reg(REG_LINE_LENGTH, CFG_DATA_W'(2));
        write_reg(REG_LINE_COUNT, CFG_DATA_W'(2));
        tile = '{32'd5, 32'd7, 32'hffff_8000, 32'd3, 32'd11, '0, VAL_MAX, 32'h0000_8000, '1};
        foreach (tile[i]) send_sample(tile[i]);
        drain_results();
    endtask

    // all-ones length clamps to the widest line; one full line plus part of the next
    task automatic test_widest_lines();
        int                 items;
        logic [VALUE_W-1:0] level;
        write_reg(REG_GAIN_X, CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(REG_GAIN_Y, CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(REG_LINE_LENGTH, '1);
        write_reg(REG_LINE_COUNT, CFG_DATA_W'(3));
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        level = $urandom;
        items = LINE_CAP + 80;
        for (int k = 0; k < items; k++) begin
            send_sample(pick_sample(1'b0, level));
        end
        drain_results();
    endtask

    // all-ones count clamps to the tallest tile; positions left mid-line wrap on the new length;
    // sender holds off once until every pending beat has come
    task automatic test_tallest_tile();
        write_reg(REG_LINE_COUNT, '1);
        write_reg(REG_LINE_LENGTH, CFG_DATA_W'(4));
        for (int k = 0; k < 30; k++) begin
            if (k == 15) drain_results();
            send_sample($urandom);
        end
        drain_results();
    endtask

    task automatic test_random_tiles();
        int                 sent, items, len, cnt, r;
        bit                 rough;
        logic [VALUE_W-1:0] level;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            write_reg(REG_GAIN_X, (r == 0) ? '0 : (r == 1) ? '1 :
                      CFG_DATA_W'($urandom_range(0, 65535)));
            r = $urandom_range(0, 9);
            write_reg(REG_GAIN_Y, (r == 0) ? '0 : (r == 1) ? '1 :
                      CFG_DATA_W'($urandom_range(0, 65535)));
            r = $urandom_range(0, 99);
            if (r < 70)      len = $urandom_range(3, 12);
            else if (r < 85) len = $urandom_range(13, 64);
            else if (r < 95) len = $urandom_range(0, 2);
            else             len = 16'hf800 | $urandom_range(0, 2);  // upper bits are dropped
            write_reg(REG_LINE_LENGTH, CFG_DATA_W'(len));
            r = $urandom_range(0, 99);
            if (r < 80)      cnt = $urandom_range(3, 8);
            else if (r < 92) cnt = $urandom_range(9, 20);
            else             cnt = $urandom_range(0, 2);
            write_reg(REG_LINE_COUNT, CFG_DATA_W'(cnt));
            len   = cells_per_line();
            cnt   = lines_per_tile();
            items = len * cnt * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) items += $urandom_range(1, 2 * len);
            if (items > 200) items = 200;
            sender_gaps = ($urandom_range(0, 2) != 0);
            sink_stalls = ($urandom_range(0, 2) != 0);
            rough       = ($urandom_range(0, 3) == 0);
            level       = $urandom;
            for (int k = 0; k < items; k++) begin
                if (k == items / 2 && $urandom_range(0, 3) == 0) drain_results();
                send_sample(pick_sample(rough, level));
            end
            sent += items;
            drain_results();
        end
    endtask

    // result sink with random back-pressure
    initial begin
        int hold;
        hold    = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else if (!sink_stalls || $urandom_range(0, 99) < 70) begin
                m_ready <= 1'b1;
            end else begin
                hold = pick_gap_len() - 1;
                m_ready <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin : check_new_values
        t_cell_result want;
        if (rst_n && o_m_axis_tvalid && m_ready) begin
            if (expected_cells.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected beat: new_value %h tlast %b",
                             o_m_axis_tdata, o_m_axis_tlast);
            end else begin
                want = expected_cells.pop_front();
                if (want.value !== o_m_axis_tdata || want.tile_end !== o_m_axis_tlast) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("beat mismatch: new_value exp %h got %h, tlast exp %b got %b",
                                 want.value, o_m_axis_tdata, want.tile_end, o_m_axis_tlast);
                end
            end
        end
    end

    // ends the run when no beat moves on either side for too long
    always @(posedge clk) begin
        if (!rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("explicit_diffusion_stencil_2d: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_saturation();
        test_small_extents();
        test_widest_lines();
        test_tallest_tile();
        test_random_tiles();
        drain_results();
        if (mismatch_count == 0) begin
            $display("explicit_diffusion_stencil_2d: match");
        end else begin
            $display("explicit_diffusion_stencil_2d: mismatch");
        end
        $finish;
    end

endmodule

### explicit_diffusion_stencil_2d.f
+incdir+rtl
rtl/eds2d_pkg.sv
rtl/eds2d_line_ram.sv
rtl/eds2d_pos_ctrl.sv
rtl/eds2d_stencil.sv
rtl/explicit_diffusion_stencil_2d.sv
tb/sv/explicit_diffusion_stencil_2d_test.sv
